// ===== rtl/gea_pkg.sv =====
// ============================================================================
// gea_pkg
// Shared types, character codes and tables for the G-code extrusion
// accumulator: line parser states, line commands and queue sizing.
// ============================================================================
package gea_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int SUM_WIDTH_DEF = 40;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_2     = 8'd50;
    localparam logic [7:0] CH_3     = 8'd51;
    localparam logic [7:0] CH_8     = 8'd56;
    localparam logic [7:0] CH_9     = 8'd57;
    localparam logic [7:0] CH_E     = 8'd69;
    localparam logic [7:0] CH_G     = 8'd71;
    localparam logic [7:0] CH_M     = 8'd77;
    localparam logic [7:0] CH_X     = 8'd88;
    localparam logic [7:0] CH_Y     = 8'd89;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_M1,
        PH_M2,
        PH_GBODY,
        PH_SKIP
    } line_phase_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_M83,
        K_M82,
        K_G,
        K_GA,
        K_GB,
        K_G92
    } line_kind_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_WS,
        N_SIGN,
        N_INT,
        N_FRAC,
        N_DONE
    } num_phase_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_M83,
        OP_M82,
        OP_G92,
        OP_GMOVE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic xy_found;
    } cmd_t;

    // weight of the n-th fraction digit in micrometres
    function automatic logic [6:0] frac_scale(input logic [1:0] n);
        logic [6:0] s;
        begin
            unique case (n)
                2'd0:    s = 7'd100;
                2'd1:    s = 7'd10;
                default: s = 7'd1;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== rtl/gea_front.sv =====
// ============================================================================
// gea_front
// Line parser: classifies each line, decodes the E word to micrometres and
// emits one command request per closed line into the queue.
// ============================================================================
module gea_front #(
    parameter int POS_WIDTH = gea_pkg::POS_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_text_byte,
    input  logic                        s_chunk_end,
    input  logic                        q_full,
    output logic                        q_push,
    output gea_pkg::cmd_t               q_cmd,
    output logic signed [POS_WIDTH-1:0] q_value
);

    localparam int MW  = POS_WIDTH - 1;
    localparam int NVW = POS_WIDTH + 4;
    localparam logic [MW-1:0] MAG_MAX = {MW{1'b1}};

    gea_pkg::line_phase_t line_phase_reg, line_phase_next, phase_fed;
    gea_pkg::line_kind_t  line_kind_reg, line_kind_next, kind_fed;
    gea_pkg::num_phase_t  num_phase_reg, num_phase_next, nph_fed;
    logic          prev_blank_reg, prev_blank_next, pb_fed;
    logic          e_found_reg, e_found_next, e_fed;
    logic          xy_found_reg, xy_found_next, xy_fed;
    logic          num_neg_reg, num_neg_next, neg_fed;
    logic [MW-1:0] num_mag_reg, num_mag_next, mag_fed;
    logic [1:0]    frac_digits_reg, frac_digits_next, fd_fed;

    logic          accept, is_nl, is_blank, is_ws, is_digit, is_sign, take_int;
    logic [3:0]    digit;
    logic [NVW-1:0]       int_wide;
    logic [POS_WIDTH-1:0] frac_wide;
    logic [MW-1:0] int_sat, frac_sat;

    gea_pkg::line_kind_t  c_kind;
    logic                 c_e, c_xy, c_neg;
    logic [MW-1:0]        c_mag;
    logic [POS_WIDTH-1:0] c_mag_ext;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_nl    = (s_text_byte == gea_pkg::CH_NL);
    assign is_blank = (s_text_byte == gea_pkg::CH_SPACE) || (s_text_byte == gea_pkg::CH_TAB);
    assign is_ws    = is_blank || (s_text_byte == gea_pkg::CH_CR)
                   || (s_text_byte == gea_pkg::CH_VT) || (s_text_byte == gea_pkg::CH_FF);
    assign is_digit = (s_text_byte >= gea_pkg::CH_0) && (s_text_byte <= gea_pkg::CH_9);
    assign is_sign  = (s_text_byte == gea_pkg::CH_PLUS) || (s_text_byte == gea_pkg::CH_MINUS);
    assign digit    = 4'(s_text_byte - gea_pkg::CH_0);

    assign int_wide  = (NVW'(num_mag_reg) << 3) + (NVW'(num_mag_reg) << 1)
                     + NVW'(digit) * NVW'(1000);
    assign int_sat   = (int_wide > NVW'(MAG_MAX)) ? MAG_MAX : int_wide[MW-1:0];
    assign frac_wide = POS_WIDTH'(num_mag_reg)
                     + POS_WIDTH'(digit) * POS_WIDTH'(gea_pkg::frac_scale(frac_digits_reg));
    assign frac_sat  = (frac_wide > POS_WIDTH'(MAG_MAX)) ? MAG_MAX : frac_wide[MW-1:0];

    assign take_int = ((num_phase_reg == gea_pkg::N_WS) && !is_ws && !is_sign)
                   || (num_phase_reg == gea_pkg::N_SIGN) || (num_phase_reg == gea_pkg::N_INT);

    always_comb begin
        phase_fed = line_phase_reg;
        kind_fed  = line_kind_reg;
        pb_fed    = prev_blank_reg;
        e_fed     = e_found_reg;
        xy_fed    = xy_found_reg;
        nph_fed   = num_phase_reg;
        neg_fed   = num_neg_reg;
        mag_fed   = num_mag_reg;
        fd_fed    = frac_digits_reg;
        unique case (line_phase_reg)
            gea_pkg::PH_LEAD: begin
                if (!is_blank) begin
                    if (s_text_byte == gea_pkg::CH_M) begin
                        phase_fed = gea_pkg::PH_M1;
                    end else if (s_text_byte == gea_pkg::CH_G) begin
                        phase_fed = gea_pkg::PH_GBODY;
                        kind_fed  = gea_pkg::K_GA;
                        pb_fed    = 1'b0;
                    end else begin
                        phase_fed = gea_pkg::PH_SKIP;
                    end
                end
            end
            gea_pkg::PH_M1: begin
                phase_fed = (s_text_byte == gea_pkg::CH_8) ? gea_pkg::PH_M2 : gea_pkg::PH_SKIP;
            end
            gea_pkg::PH_M2: begin
                if (s_text_byte == gea_pkg::CH_3) begin
                    kind_fed = gea_pkg::K_M83;
                end else if (s_text_byte == gea_pkg::CH_2) begin
                    kind_fed = gea_pkg::K_M82;
                end
                phase_fed = gea_pkg::PH_SKIP;
            end
            gea_pkg::PH_GBODY: begin
                if (line_kind_reg == gea_pkg::K_GA) begin
                    kind_fed = (s_text_byte == gea_pkg::CH_9) ? gea_pkg::K_GB : gea_pkg::K_G;
                end else if (line_kind_reg == gea_pkg::K_GB) begin
                    kind_fed = (s_text_byte == gea_pkg::CH_2) ? gea_pkg::K_G92 : gea_pkg::K_G;
                end
                if (e_found_reg) begin
                    if (take_int) begin
                        if (is_digit) begin
                            mag_fed = int_sat;
                            nph_fed = gea_pkg::N_INT;
                        end else if (s_text_byte == gea_pkg::CH_DOT) begin
                            nph_fed = gea_pkg::N_FRAC;
                        end else begin
                            nph_fed = gea_pkg::N_DONE;
                        end
                    end else if (num_phase_reg == gea_pkg::N_WS) begin
                        if (is_sign) begin
                            neg_fed = (s_text_byte == gea_pkg::CH_MINUS);
                            nph_fed = gea_pkg::N_SIGN;
                        end
                    end else if (num_phase_reg == gea_pkg::N_FRAC) begin
                        if (is_digit) begin
                            if (frac_digits_reg != 2'd3) begin
                                mag_fed = frac_sat;
                                fd_fed  = frac_digits_reg + 2'd1;
                            end
                        end else begin
                            nph_fed = gea_pkg::N_DONE;
                        end
                    end
                end else if (prev_blank_reg && (s_text_byte == gea_pkg::CH_E)) begin
                    e_fed   = 1'b1;
                    nph_fed = gea_pkg::N_WS;
                end
                if (prev_blank_reg && ((s_text_byte == gea_pkg::CH_X)
                                    || (s_text_byte == gea_pkg::CH_Y))) begin
                    xy_fed = 1'b1;
                end
                pb_fed = is_blank;
            end
            default: begin
            end
        endcase
    end

    // a newline closes on the state before it; chunk end closes after the byte
    always_comb begin
        q_push = accept && (is_nl || s_chunk_end);
        c_kind = is_nl ? line_kind_reg   : kind_fed;
        c_e    = is_nl ? e_found_reg     : e_fed;
        c_xy   = is_nl ? xy_found_reg    : xy_fed;
        c_neg  = is_nl ? num_neg_reg     : neg_fed;
        c_mag  = is_nl ? num_mag_reg     : mag_fed;
        c_mag_ext   = POS_WIDTH'(c_mag);
        q_value     = c_neg ? -c_mag_ext : c_mag_ext;
        q_cmd.xy_found = c_xy;
        priority if (c_kind == gea_pkg::K_M83) begin
            q_cmd.op = gea_pkg::OP_M83;
        end else if (c_kind == gea_pkg::K_M82) begin
            q_cmd.op = gea_pkg::OP_M82;
        end else if (c_kind == gea_pkg::K_NONE || !c_e) begin
            q_cmd.op = gea_pkg::OP_NONE;
        end else if (c_kind == gea_pkg::K_G92) begin
            q_cmd.op = gea_pkg::OP_G92;
        end else begin
            q_cmd.op = gea_pkg::OP_GMOVE;
        end
    end

    always_comb begin
        if (q_push) begin
            line_phase_next  = gea_pkg::PH_LEAD;
            line_kind_next   = gea_pkg::K_NONE;
            prev_blank_next  = 1'b0;
            e_found_next     = 1'b0;
            xy_found_next    = 1'b0;
            num_phase_next   = gea_pkg::N_IDLE;
            num_neg_next     = 1'b0;
            num_mag_next     = '0;
            frac_digits_next = 2'd0;
        end else if (accept) begin
            line_phase_next  = phase_fed;
            line_kind_next   = kind_fed;
            prev_blank_next  = pb_fed;
            e_found_next     = e_fed;
            xy_found_next    = xy_fed;
            num_phase_next   = nph_fed;
            num_neg_next     = neg_fed;
            num_mag_next     = mag_fed;
            frac_digits_next = fd_fed;
        end else begin
            line_phase_next  = line_phase_reg;
            line_kind_next   = line_kind_reg;
            prev_blank_next  = prev_blank_reg;
            e_found_next     = e_found_reg;
            xy_found_next    = xy_found_reg;
            num_phase_next   = num_phase_reg;
            num_neg_next     = num_neg_reg;
            num_mag_next     = num_mag_reg;
            frac_digits_next = frac_digits_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_phase_reg  <= gea_pkg::PH_LEAD;
            line_kind_reg   <= gea_pkg::K_NONE;
            prev_blank_reg  <= 1'b0;
            e_found_reg     <= 1'b0;
            xy_found_reg    <= 1'b0;
            num_phase_reg   <= gea_pkg::N_IDLE;
            num_neg_reg     <= 1'b0;
            num_mag_reg     <= '0;
            frac_digits_reg <= 2'd0;
        end else begin
            line_phase_reg  <= line_phase_next;
            line_kind_reg   <= line_kind_next;
            prev_blank_reg  <= prev_blank_next;
            e_found_reg     <= e_found_next;
            xy_found_reg    <= xy_found_next;
            num_phase_reg   <= num_phase_next;
            num_neg_reg     <= num_neg_next;
            num_mag_reg     <= num_mag_next;
            frac_digits_reg <= frac_digits_next;
        end
    end

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> (line_phase_reg == gea_pkg::PH_LEAD) && !e_found_reg && (num_mag_reg == '0))
        else $error("line state not cleared after close");

endmodule

// ===== rtl/gea_queue.sv =====
// ============================================================================
// gea_queue
// Short command queue between the line parser and the executor.
// ============================================================================
module gea_queue #(
    parameter int POS_WIDTH = gea_pkg::POS_WIDTH_DEF,
    parameter int DEPTH     = gea_pkg::QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  gea_pkg::cmd_t               push_cmd,
    input  logic signed [POS_WIDTH-1:0] push_value,
    output logic                        full,
    input  logic                        pop,
    output logic                        not_empty,
    output gea_pkg::cmd_t               pop_cmd,
    output logic signed [POS_WIDTH-1:0] pop_value
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gea_pkg::cmd_t               cmd_reg [DEPTH];
    logic signed [POS_WIDTH-1:0] value_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = cmd_reg[rd_ptr_reg];
    assign pop_value = value_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ((wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1))
                           : wr_ptr_reg;
        rd_ptr_next = pop  ? ((rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1))
                           : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_reg[wr_ptr_reg]   <= push_cmd;
            value_reg[wr_ptr_reg] <= push_value;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty))
        else $error("queue read while empty");

endmodule

// ===== rtl/gea_back.sv =====
// ============================================================================
// gea_back
// Executor: applies each line command to the mode flag, extruder position
// and filament total, and holds the result for the output channel.
// ============================================================================
module gea_back #(
    parameter int POS_WIDTH = gea_pkg::POS_WIDTH_DEF,
    parameter int SUM_WIDTH = gea_pkg::SUM_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  gea_pkg::cmd_t               q_cmd,
    input  logic signed [POS_WIDTH-1:0] q_value,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [SUM_WIDTH-1:0]        m_filament_total,
    output logic signed [POS_WIDTH-1:0] m_e_position,
    output logic                        m_relative_mode,
    output logic                        m_line_had_e
);

    localparam int AW = ((SUM_WIDTH > POS_WIDTH + 1) ? SUM_WIDTH : POS_WIDTH + 1) + 1;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};
    localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    logic                        valid_reg, valid_next;
    logic [SUM_WIDTH-1:0]        sum_reg, sum_next;
    logic signed [POS_WIDTH-1:0] pos_reg, pos_next;
    logic                        rel_reg, rel_next;
    logic                        had_e_reg, had_e_next;

    logic signed [POS_WIDTH:0] v_ext, delta, addend, pos_sum;
    logic signed [POS_WIDTH-1:0] pos_clamped;
    logic [AW-1:0]             sum_wide;
    logic [SUM_WIDTH-1:0]      sum_sat;
    logic                      v_pos, d_pos;

    assign q_pop = q_valid && (!valid_reg || m_ready);

    assign v_ext   = {q_value[POS_WIDTH-1], q_value};
    assign delta   = v_ext - {pos_reg[POS_WIDTH-1], pos_reg};
    assign pos_sum = v_ext + {pos_reg[POS_WIDTH-1], pos_reg};
    assign v_pos   = !v_ext[POS_WIDTH] && (v_ext != '0);
    assign d_pos   = !delta[POS_WIDTH] && (delta != '0);
    assign addend  = rel_reg ? v_ext : delta;
    assign sum_wide = AW'(sum_reg) + AW'($unsigned(addend));
    assign sum_sat  = (sum_wide > AW'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_WIDTH-1:0];

    always_comb begin
        if (pos_sum[POS_WIDTH] != pos_sum[POS_WIDTH-1]) begin
            pos_clamped = pos_sum[POS_WIDTH] ? POS_MIN : POS_MAX;
        end else begin
            pos_clamped = pos_sum[POS_WIDTH-1:0];
        end
    end

    always_comb begin
        valid_next = q_pop ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
        sum_next   = sum_reg;
        pos_next   = pos_reg;
        rel_next   = rel_reg;
        had_e_next = had_e_reg;
        if (q_pop) begin
            had_e_next = 1'b0;
            unique case (q_cmd.op)
                gea_pkg::OP_M83: rel_next = 1'b1;
                gea_pkg::OP_M82: rel_next = 1'b0;
                gea_pkg::OP_G92: begin
                    pos_next   = q_value;
                    had_e_next = 1'b1;
                end
                gea_pkg::OP_GMOVE: begin
                    had_e_next = 1'b1;
                    if (rel_reg) begin
                        if (v_pos && q_cmd.xy_found) begin
                            sum_next = sum_sat;
                        end else if (!q_cmd.xy_found) begin
                            pos_next = pos_clamped;
                        end
                    end else begin
                        if (d_pos && q_cmd.xy_found) begin
                            sum_next = sum_sat;
                        end
                        pos_next = q_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sum_reg   <= '0;
            pos_reg   <= '0;
            rel_reg   <= 1'b0;
            had_e_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sum_reg   <= sum_next;
            pos_reg   <= pos_next;
            rel_reg   <= rel_next;
            had_e_reg <= had_e_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_filament_total = sum_reg;
    assign m_e_position     = pos_reg;
    assign m_relative_mode  = rel_reg;
    assign m_line_had_e     = had_e_reg;

    a_sum_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (sum_reg >= $past(sum_reg)))
        else $error("filament total decreased");

    a_m83_sets_relative: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && (q_cmd.op == gea_pkg::OP_M83)) |=> m_relative_mode && !m_line_had_e)
        else $error("M83 not applied");

endmodule

// ===== rtl/gcode_extrusion_accumulator.sv =====
// ============================================================================
// gcode_extrusion_accumulator
// G-code text in, one extrusion summary per closed line out.
// ============================================================================
// Feed text one byte per request on s_ (s_text_byte, s_chunk_end); a newline
// or a byte with s_chunk_end set closes the line. Each closed line gives one
// request on m_ with the filament total, the extruder position, the E mode
// and whether the line was a G line carrying an E word.
// Throughput: one byte per cycle, bytes and line results alike, while m_ready
// stays high and the queue has room. The edge that takes the closing byte writes
// the line command into the queue; the executor then pops it and registers its
// result, which raises m_valid.
// Parser and executor sit on either side of a four-entry command queue; a
// stalled m_ready fills the queue and s_ready drops only when it is full.
// Results leave in line order and are held on m_ until taken.
// Reset (aresetn low at a clock edge) returns absolute mode, zero position,
// zero total and a fresh line; the block accepts bytes in the next cycle.
// ============================================================================
module gcode_extrusion_accumulator #(
    parameter int POS_WIDTH = gea_pkg::POS_WIDTH_DEF,
    parameter int SUM_WIDTH = gea_pkg::SUM_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_text_byte,
    input  logic                        s_chunk_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [SUM_WIDTH-1:0]        m_filament_total,
    output logic signed [POS_WIDTH-1:0] m_e_position,
    output logic                        m_relative_mode,
    output logic                        m_line_had_e
);

    logic                        push, full, pop, not_empty;
    gea_pkg::cmd_t               push_cmd, pop_cmd;
    logic signed [POS_WIDTH-1:0] push_value, pop_value;

    gea_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .s_chunk_end (s_chunk_end),
        .q_full      (full),
        .q_push      (push),
        .q_cmd       (push_cmd),
        .q_value     (push_value)
    );

    gea_queue #(
        .POS_WIDTH (POS_WIDTH),
        .DEPTH     (gea_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_value (push_value),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .pop_cmd    (pop_cmd),
        .pop_value  (pop_value)
    );

    gea_back #(
        .POS_WIDTH (POS_WIDTH),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (not_empty),
        .q_cmd            (pop_cmd),
        .q_value          (pop_value),
        .q_pop            (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filament_total (m_filament_total),
        .m_e_position     (m_e_position),
        .m_relative_mode  (m_relative_mode),
        .m_line_had_e     (m_line_had_e)
    );

endmodule

// ===== tb/gcode_extrusion_accumulator_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// gcode_extrusion_accumulator_tb
// Self-checking bench for the G-code extrusion accumulator.
// ============================================================================
// G-code text is streamed in one byte per request: a short directed set of
// lines, a random mix of move, position-set, mode and junk lines, and a run
// of wide absolute moves that pushes the filament total past 32 bits. A
// line-level model built into the bench predicts the summary of each closed
// line, and every summary taken from the block is checked field by field in
// line order. The sender runs in bursts and the receiver stalls on patterns
// and long hold-offs.
// ============================================================================
module gcode_extrusion_accumulator_tb;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_TICKS = 7;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_TICKS = 8;
    localparam int RANDOM_BYTES = 1000;
    localparam int SAT_PAIRS   = 20;
    localparam int REPORT_CAP  = 40;
    localparam int POS_W = gea_pkg::POS_WIDTH_DEF;
    localparam int SUM_W = gea_pkg::SUM_WIDTH_DEF;
    localparam longint POS_MAX = longint'((64'd1 << (POS_W - 1)) - 64'd1);
    localparam longint POS_MIN = -POS_MAX - 1;
    localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 64'd1;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [POS_W-1:0] pos;
        logic             rel;
        logic             had_e;
    } line_summary_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       ce;
        logic       drain;
    } text_req_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_text_byte = 8'd0;
    logic                    s_chunk_end = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [SUM_W-1:0]        m_filament_total;
    logic signed [POS_W-1:0] m_e_position;
    logic                    m_relative_mode;
    logic                    m_line_had_e;

    text_req_t     text_backlog[$];
    line_summary_t expected_summaries[$];

    // line model state
    logic                 rel_mode;
    longint               e_pos;
    longint unsigned      fil_sum;
    gea_pkg::line_phase_t line_state;
    gea_pkg::line_kind_t  cmd_kind;
    gea_pkg::num_phase_t  value_state;
    logic                 prev_was_blank;
    logic                 e_word_seen;
    logic                 xy_word_seen;
    logic                 value_neg;
    longint unsigned      value_mag;
    int                   frac_count;

    int        cycle_count = 0;
    int        error_count = 0;
    int        bytes_sent = 0;
    int        results_seen = 0;
    int        lines_with_e = 0;
    int        relative_results = 0;
    int        input_stall_cycles = 0;
    int        drain_count = 0;
    bit        req_taken = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        hold_left = 0;
    int        next_hold_at = 30;
    int        holds_done = 0;
    int        pattern_left = 0;
    int        pattern_mode = 0;
    logic [7:0] stall_pattern = 8'hff;
    text_req_t next_req;

    gcode_extrusion_accumulator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_byte      (s_text_byte),
        .s_chunk_end      (s_chunk_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filament_total (m_filament_total),
        .m_e_position     (m_e_position),
        .m_relative_mode  (m_relative_mode),
        .m_line_had_e     (m_line_had_e)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // line model
    // ------------------------------------------------------------------
    function automatic void start_new_line();
        line_state     = gea_pkg::PH_LEAD;
        cmd_kind       = gea_pkg::K_NONE;
        value_state    = gea_pkg::N_IDLE;
        prev_was_blank = 1'b0;
        e_word_seen    = 1'b0;
        xy_word_seen   = 1'b0;
        value_neg      = 1'b0;
        value_mag      = 0;
        frac_count     = 0;
    endfunction

    function automatic void feed_value_char(input logic [7:0] c);
        logic digit;
        logic ws;
        longint unsigned acc;
        digit = (c >= gea_pkg::CH_0) && (c <= gea_pkg::CH_9);
        ws = (c == gea_pkg::CH_SPACE) || (c == gea_pkg::CH_TAB) || (c == gea_pkg::CH_CR)
          || (c == gea_pkg::CH_VT) || (c == gea_pkg::CH_FF);
        if (value_state == gea_pkg::N_WS && ws) begin
        end else if (value_state == gea_pkg::N_WS
                     && (c == gea_pkg::CH_PLUS || c == gea_pkg::CH_MINUS)) begin
            value_neg   = (c == gea_pkg::CH_MINUS);
            value_state = gea_pkg::N_SIGN;
        end else if (value_state == gea_pkg::N_WS || value_state == gea_pkg::N_SIGN
                     || value_state == gea_pkg::N_INT) begin
            if (digit) begin
                acc = value_mag * 10 + longint'(c - gea_pkg::CH_0) * 1000;
                value_mag   = (acc > POS_MAX) ? POS_MAX : acc;
                value_state = gea_pkg::N_INT;
            end else if (c == gea_pkg::CH_DOT) begin
                value_state = gea_pkg::N_FRAC;
            end else begin
                value_state = gea_pkg::N_DONE;
            end
        end else if (value_state == gea_pkg::N_FRAC) begin
            if (!digit) begin
                value_state = gea_pkg::N_DONE;
            end else if (frac_count < 3) begin
                acc = value_mag + longint'(c - gea_pkg::CH_0) *
                      ((frac_count == 0) ? 100 : (frac_count == 1) ? 10 : 1);
                value_mag  = (acc > POS_MAX) ? POS_MAX : acc;
                frac_count = frac_count + 1;
            end
        end
    endfunction

    function automatic void feed_text_char(input logic [7:0] c);
        logic blank;
        blank = (c == gea_pkg::CH_SPACE) || (c == gea_pkg::CH_TAB);
        case (line_state)
            gea_pkg::PH_LEAD: begin
                if (!blank) begin
                    if (c == gea_pkg::CH_M) begin
                        line_state = gea_pkg::PH_M1;
                    end else if (c == gea_pkg::CH_G) begin
                        line_state     = gea_pkg::PH_GBODY;
                        cmd_kind       = gea_pkg::K_GA;
                        prev_was_blank = 1'b0;
                    end else begin
                        line_state = gea_pkg::PH_SKIP;
                    end
                end
            end
            gea_pkg::PH_M1: begin
                if (c == gea_pkg::CH_8) line_state = gea_pkg::PH_M2;
                else line_state = gea_pkg::PH_SKIP;
            end
            gea_pkg::PH_M2: begin
                if (c == gea_pkg::CH_3) cmd_kind = gea_pkg::K_M83;
                else if (c == gea_pkg::CH_2) cmd_kind = gea_pkg::K_M82;
                line_state = gea_pkg::PH_SKIP;
            end
            gea_pkg::PH_GBODY: begin
                if (cmd_kind == gea_pkg::K_GA) begin
                    if (c == gea_pkg::CH_9) cmd_kind = gea_pkg::K_GB;
                    else cmd_kind = gea_pkg::K_G;
                end else if (cmd_kind == gea_pkg::K_GB) begin
                    if (c == gea_pkg::CH_2) cmd_kind = gea_pkg::K_G92;
                    else cmd_kind = gea_pkg::K_G;
                end
                if (e_word_seen) begin
                    feed_value_char(c);
                end else if (prev_was_blank && c == gea_pkg::CH_E) begin
                    e_word_seen = 1'b1;
                    value_state = gea_pkg::N_WS;
                end
                if (prev_was_blank && (c == gea_pkg::CH_X || c == gea_pkg::CH_Y))
                    xy_word_seen = 1'b1;
                prev_was_blank = blank;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void add_filament(input longint unsigned amount);
        if (amount > SUM_MAX - fil_sum) fil_sum = SUM_MAX;
        else fil_sum = fil_sum + amount;
    endfunction

    function automatic line_summary_t close_line();
        line_summary_t r;
        logic          had_e;
        longint        v;
        longint        moved;
        had_e = e_word_seen && (cmd_kind == gea_pkg::K_G || cmd_kind == gea_pkg::K_GA ||
                                cmd_kind == gea_pkg::K_GB || cmd_kind == gea_pkg::K_G92);
        if (cmd_kind == gea_pkg::K_M83) begin
            rel_mode = 1'b1;
        end else if (cmd_kind == gea_pkg::K_M82) begin
            rel_mode = 1'b0;
        end else if (had_e) begin
            v = value_neg ? -longint'(value_mag) : longint'(value_mag);
            if (cmd_kind == gea_pkg::K_G92) begin
                e_pos = v;
            end else if (rel_mode) begin
                if (v > 0 && xy_word_seen) begin
                    add_filament(v);
                end else if (!xy_word_seen) begin
                    moved = e_pos + v;
                    e_pos = (moved > POS_MAX) ? POS_MAX : (moved < POS_MIN) ? POS_MIN : moved;
                end
            end else begin
                moved = v - e_pos;
                if (moved > 0 && xy_word_seen) add_filament(moved);
                e_pos = v;
            end
        end
        r.total = fil_sum[SUM_W-1:0];
        r.pos   = e_pos[POS_W-1:0];
        r.rel   = rel_mode;
        r.had_e = had_e;
        start_new_line();
        return r;
    endfunction

    function automatic bit take_text_byte(input logic [7:0] c, input logic ce,
                                          output line_summary_t r);
        r = '0;
        if (c == gea_pkg::CH_NL) begin
            r = close_line();
            return 1'b1;
        end
        feed_text_char(c);
        if (ce) begin
            r = close_line();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // text generation
    // ------------------------------------------------------------------
    function automatic void push_char(input logic [7:0] c, input logic ce = 1'b0);
        text_req_t t;
        t.ch    = c;
        t.ce    = ce;
        t.drain = 1'b0;
        text_backlog.insert(text_backlog.size(), t);
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endfunction

    function automatic void push_drain();
        text_req_t t;
        t = '0;
        t.drain = 1'b1;
        text_backlog.insert(text_backlog.size(), t);
    endfunction

    function automatic void end_line();
        int last;
        last = text_backlog.size() - 1;
        case ($urandom_range(0, 9))
            0: begin
                if (last >= 0 && !text_backlog[last].drain
                    && text_backlog[last].ch != gea_pkg::CH_NL)
                    text_backlog[last].ce = 1'b1;
                else
                    push_char(gea_pkg::CH_NL);
            end
            1: push_char(gea_pkg::CH_NL, 1'b1);
            default: push_char(gea_pkg::CH_NL);
        endcase
    endfunction

    function automatic void push_blanks(input int n);
        for (int i = 0; i < n; i++)
            push_char($urandom_range(0, 1) ? gea_pkg::CH_SPACE : gea_pkg::CH_TAB);
    endfunction

    function automatic void push_digits(input int n);
        for (int i = 0; i < n; i++) push_char(8'(gea_pkg::CH_0 + $urandom_range(0, 9)));
    endfunction

    function automatic void push_number();
        string junk;
        int    n;
        junk = "eExX;nF";
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0: push_char(gea_pkg::CH_SPACE);
                1: push_char(gea_pkg::CH_TAB);
                2: push_char(gea_pkg::CH_CR);
                3: push_char(gea_pkg::CH_VT);
                default: push_char(gea_pkg::CH_FF);
            endcase
        end
        case ($urandom_range(0, 5))
            0, 1: push_char(gea_pkg::CH_MINUS);
            2: push_char(gea_pkg::CH_PLUS);
            default: begin
            end
        endcase
        push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 3));
        if ($urandom_range(0, 2) != 0) begin
            push_char(gea_pkg::CH_DOT);
            push_digits($urandom_range(0, 5));
        end
        if ($urandom_range(0, 7) == 0) begin
            push_char(junk[$urandom_range(0, junk.len() - 1)]);
            push_digits($urandom_range(0, 2));
        end
    endfunction

    function automatic void push_word_gap();
        if ($urandom_range(0, 6) != 0) push_blanks($urandom_range(1, 2));
    endfunction

    function automatic void push_g_line(input bit set_pos);
        int n_words;
        int e_slot;
        bit put_e;
        push_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        push_char(gea_pkg::CH_G);
        if (set_pos) begin
            push_str("92");
        end else begin
            case ($urandom_range(0, 5))
                0: push_str("0");
                1: push_str("9");
                2: push_str("91");
                3: begin
                end
                default: push_str("1");
            endcase
        end
        n_words = $urandom_range(0, 4);
        e_slot  = $urandom_range(0, n_words);
        put_e   = ($urandom_range(0, 4) != 0);
        for (int i = 0; i <= n_words; i++) begin
            if (put_e && i == e_slot) begin
                push_word_gap();
                push_char(gea_pkg::CH_E);
                push_number();
            end
            if (i < n_words) begin
                push_word_gap();
                case ($urandom_range(0, 9))
                    0, 1, 2: push_char(gea_pkg::CH_X);
                    3, 4: push_char(gea_pkg::CH_Y);
                    5: push_char("Z");
                    6: push_char("F");
                    7: push_char(gea_pkg::CH_E);
                    8: push_char("x");
                    default: push_char(8'($urandom_range(65, 90)));
                endcase
                push_digits($urandom_range(0, 3));
                if ($urandom_range(0, 1)) begin
                    push_char(gea_pkg::CH_DOT);
                    push_digits($urandom_range(0, 3));
                end
            end
        end
        if ($urandom_range(0, 9) == 0) push_str(" ; note");
        end_line();
    endfunction

    function automatic void push_mode_line();
        case ($urandom_range(0, 11))
            0, 1: push_str("M83");
            2, 3: push_str("M82");
            4: push_str("M830");
            5: push_str("M8");
            6: push_str("M84");
            7: push_str("M 83");
            8: push_str("M82 ; absolute");
            9: push_str("m83");
            10: push_str(" \tM83");
            default: push_str("M1");
        endcase
        end_line();
    endfunction

    function automatic void push_junk_line();
        int n;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
            push_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end_line();
    endfunction

    function automatic void build_text();
        int stop_at;
        int drain_at;
        // directed lines
        push_str("\n");
        push_str("M83\n");
        push_str("G1 X10 E1.5\n");
        push_str("G1 E-.25\n");
        push_str("G1 X1 E\n");
        push_str("G1 Y2 E-\n");
        push_str("G1 E99999999999\n");
        push_str("G1 E99999999999\n");
        push_str("G92 E-99999999999\n");
        push_str("G1 E-1\n");
        push_str("M82\n");
        push_str("G1 X5 E2.12345\n");
        push_str("G1 Y5 E9e3\n");
        push_str("G1 X E0x1F\n");
        push_str("M830\n");
        push_str("G1 X E \t+3.\n");
        push_str("G1 X2 E7");
        push_char(gea_pkg::CH_NL, 1'b1);
        push_str("G1E4 X1");
        push_char(gea_pkg::CH_9, 1'b1);
        push_str("T0\n");
        push_drain();
        // random mix
        stop_at  = text_backlog.size() + RANDOM_BYTES;
        drain_at = text_backlog.size() + 500;
        while (text_backlog.size() < stop_at) begin
            case ($urandom_range(0, 19))
                0, 1: push_g_line(1'b1);
                2, 3, 4: push_mode_line();
                5, 6: push_junk_line();
                7: push_str("\n");
                8: begin
                    push_str(";");
                    push_digits($urandom_range(0, 4));
                    end_line();
                end
                default: push_g_line(1'b0);
            endcase
            if (text_backlog.size() >= drain_at) begin
                push_drain();
                drain_at = drain_at + 500;
            end
        end
        push_char(gea_pkg::CH_NL);
        push_drain();
        // wide absolute moves carry the filament total past 32 bits
        push_str("M82\n");
        for (int i = 0; i < SAT_PAIRS; i++) begin
            push_str("G92 E-2147484\n");
            push_str("G1 X1 E2147484\n");
        end
        push_str("M83\nG1 X1 E5\nG1 E-3\n");
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts with random gaps, inputs change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !req_taken)) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (text_backlog.size() == 0) begin
                s_valid <= 1'b0;
            end else if (text_backlog[0].drain) begin
                s_valid <= 1'b0;
                if (expected_summaries.size() == 0) begin
                    void'(text_backlog.pop_front());
                    drain_count = drain_count + 1;
                end
            end else begin
                next_req = text_backlog.pop_front();
                s_valid     <= 1'b1;
                s_text_byte <= next_req.ch;
                s_chunk_end <= next_req.ce;
                if (burst_left > 0) burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall patterns and long hold-offs
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (results_seen >= next_hold_at) begin
            hold_left    = 300;
            next_hold_at = next_hold_at + 250;
            holds_done   = holds_done + 1;
            m_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_mode  = $urandom_range(0, 3);
                pattern_left  = $urandom_range(20, 150);
                stall_pattern = 8'($urandom_range(1, 255));
            end
            pattern_left  = pattern_left - 1;
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            case (pattern_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= stall_pattern[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // prediction and checking on the rising edge
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string field, input longint want, input longint got);
        error_count = error_count + 1;
        if (error_count <= REPORT_CAP)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge aclk) begin
        line_summary_t want;
        line_summary_t fresh;
        if (aresetn) begin
            if (s_valid && !s_ready) input_stall_cycles = input_stall_cycles + 1;
            if (m_valid && m_ready) begin
                results_seen = results_seen + 1;
                if (expected_summaries.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= REPORT_CAP)
                        $display("%0t ns: unexpected result, expected none, got total %0d position %0d",
                                 $time, m_filament_total, m_e_position);
                end else begin
                    want = expected_summaries.pop_front();
                    if (m_filament_total !== want.total)
                        note_mismatch("filament_total", longint'(want.total),
                                      longint'(m_filament_total));
                    if (m_e_position !== want.pos)
                        note_mismatch("e_position", longint'($signed(want.pos)),
                                      longint'(m_e_position));
                    if (m_relative_mode !== want.rel)
                        note_mismatch("relative_mode", longint'(want.rel),
                                      longint'(m_relative_mode));
                    if (m_line_had_e !== want.had_e)
                        note_mismatch("line_had_e", longint'(want.had_e),
                                      longint'(m_line_had_e));
                end
            end
            if (s_valid && s_ready) begin
                req_taken = 1'b1;
                bytes_sent = bytes_sent + 1;
                if (take_text_byte(s_text_byte, s_chunk_end, fresh)) begin
                    expected_summaries.insert(expected_summaries.size(), fresh);
                    if (fresh.had_e) lines_with_e = lines_with_e + 1;
                    if (fresh.rel) relative_results = relative_results + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_summaries.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        rel_mode = 1'b0;
        e_pos    = 0;
        fil_sum  = 0;
        start_new_line();
        build_text();
        repeat (RESET_TICKS) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (text_backlog.size() != 0 || s_valid) @(posedge aclk);
        while (expected_summaries.size() != 0) @(posedge aclk);
        repeat (DRAIN_TICKS) @(posedge aclk);
        $display("Covered %0d text bytes and %0d line summaries (%0d with an E word, %0d relative)",
                 bytes_sent, results_seen, lines_with_e, relative_results);
        $display("Input back-pressure %0d cycles, %0d hold-offs, %0d drains, final total %0d um",
                 input_stall_cycles, holds_done, drain_count, fil_sum);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gea_pkg.sv
rtl/gea_front.sv
rtl/gea_queue.sv
rtl/gea_back.sv
rtl/gcode_extrusion_accumulator.sv
tb/gcode_extrusion_accumulator_tb.sv
